### hw/rtl/hmp_pkg.sv
package hmp_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        end_of_message;
  } hmp_in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic        message_done;
  } hmp_out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PAD  = 2'b10
  } hmp_state_t;

  localparam logic [3:0]  WORD_BYTES = 4'd8;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [63:0] PAD_WORD   = 64'h8000_0000_0000_0000;

endpackage

### hw/rtl/hash_message_padder_unit.sv
// Full message words pass through registered, one per cycle while output moves.
// The last word of a message yields 2 to CHUNK_BYTES/8+2 words, one per cycle
// while the output is taken; input is held off until the length word has left.
// A single 61-bit adder on the byte count serves both the per-word +8 and the
// final +valid_bytes. rst (synchronous) clears the count, the state, the output
// valid and length_big_endian; no clearing pass is needed.
module hash_message_padder_unit #(
  parameter int CHUNK_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  hmp_pkg::hmp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hmp_pkg::hmp_out_t out_data
);

  localparam int CW = CHUNK_BYTES / 8;
  localparam int WW = (CW > 1) ? $clog2(CW) : 1;
  localparam logic [WW-1:0] CW_LAST = WW'(CW - 1);

  hmp_pkg::hmp_state_t state, state_next;
  logic [60:0]         byte_count, byte_count_next;
  logic [WW-1:0]       wic, wic_next;
  logic [WW-1:0]       wpos, wpos_next;
  logic                mark, mark_next;
  logic                length_big_endian;
  logic                out_valid_next;
  hmp_pkg::hmp_out_t   out_data_next;

  logic                out_free;
  logic [3:0]          vb;
  logic [3:0]          add_b;
  logic [61:0]         sum;
  logic [63:0]         last_word;
  logic [63:0]         bits;
  logic [63:0]         len_word;
  logic [WW-1:0]       pos_n;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == hmp_pkg::ST_IDLE) && out_free;

  assign vb    = (in_data.valid_bytes > hmp_pkg::WORD_BYTES) ? hmp_pkg::WORD_BYTES
                                                             : in_data.valid_bytes;
  assign add_b = in_data.end_of_message ? vb : hmp_pkg::WORD_BYTES;
  assign sum   = {1'b0, byte_count} + 62'(add_b);
  assign bits  = {byte_count, 3'b000};
  assign pos_n = (wpos == CW_LAST) ? '0 : wpos + 1'b1;

  // data bytes, then the marker byte when fewer than eight are valid, then zeros
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < vb) begin
        last_word[63-8*j -: 8] = in_data.data_word[63-8*j -: 8];
      end else if (4'(j) == vb) begin
        last_word[63-8*j -: 8] = hmp_pkg::PAD_BYTE;
      end else begin
        last_word[63-8*j -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      len_word[63-8*j -: 8] = length_big_endian ? bits[63-8*j -: 8] : bits[8*j +: 8];
    end
  end

  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    wic_next        = wic;
    wpos_next       = wpos;
    mark_next       = mark;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    case (state)
      hmp_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          out_valid_next  = 1'b1;
          byte_count_next = sum[60:0];
          if (!in_data.end_of_message) begin
            out_data_next.out_word     = in_data.data_word;
            out_data_next.message_done = 1'b0;
            // count wrap lands exactly on zero, so the chunk position restarts
            if (sum[61] || wic == CW_LAST) begin
              wic_next = '0;
            end else begin
              wic_next = wic + 1'b1;
            end
          end else begin
            out_data_next.out_word     = last_word;
            out_data_next.message_done = 1'b0;
            mark_next  = (vb != hmp_pkg::WORD_BYTES);
            wpos_next  = wic;
            state_next = hmp_pkg::ST_PAD;
          end
        end
      end
      hmp_pkg::ST_PAD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          wpos_next      = pos_n;
          if (!mark) begin
            out_data_next.out_word     = hmp_pkg::PAD_WORD;
            out_data_next.message_done = 1'b0;
            mark_next                  = 1'b1;
          end else if (pos_n == CW_LAST) begin
            out_data_next.out_word     = len_word;
            out_data_next.message_done = 1'b1;
            byte_count_next            = '0;
            wic_next                   = '0;
            state_next                 = hmp_pkg::ST_IDLE;
          end else begin
            out_data_next.out_word     = '0;
            out_data_next.message_done = 1'b0;
          end
        end
      end
      default: begin
        state_next = hmp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= hmp_pkg::ST_IDLE;
      byte_count        <= '0;
      wic               <= '0;
      wpos              <= '0;
      mark              <= 1'b0;
      out_valid         <= 1'b0;
      length_big_endian <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      wic        <= wic_next;
      wpos       <= wpos_next;
      mark       <= mark_next;
      out_valid  <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        length_big_endian <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

### hw/rtl/hmp_checker.sv
module hmp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input hmp_pkg::hmp_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input hmp_pkg::hmp_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an item is only taken when the output stage can move
  a_in_gate: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while output blocked");

  // a full word passes straight through
  a_pass: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.end_of_message |=>
      out_valid && out_data.out_word == $past(in_data.data_word) && !out_data.message_done)
    else $error("pass-through word wrong");

  // padding always follows the last item, so input stalls
  a_pad_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.end_of_message |=> !in_ready && !out_data.message_done)
    else $error("input not held off during padding");

endmodule

bind hash_message_padder_unit hmp_checker u_hmp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
